// ----- rtl/core/tre_pkg.sv -----
// ----------------------------------------------------------------------------
// tre_pkg
// Shared types, constants and character helpers for the extended hex encoder.
// ----------------------------------------------------------------------------
package tre_pkg;

  localparam int unsigned CNT_W         = 5;   // word counts, 0..16
  localparam int unsigned WADDR_W       = 19;  // word address
  localparam int unsigned BADDR_W       = 20;  // byte address
  localparam int unsigned DATA_W        = 16;
  localparam int unsigned CHAR_W        = 8;
  localparam int unsigned MAX_WORDS_DEF = 16;

  localparam logic [CNT_W-1:0] WPR_RESET = 5'd16;

  localparam logic [CHAR_W-1:0] CH_PCT  = 8'h25;  // '%'
  localparam logic [CHAR_W-1:0] CH_0    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_5    = 8'h35;
  localparam logic [CHAR_W-1:0] CH_6    = 8'h36;
  localparam logic [CHAR_W-1:0] CH_8    = 8'h38;
  localparam logic [CHAR_W-1:0] CH_B    = 8'h42;
  localparam logic [CHAR_W-1:0] CH_NL   = 8'h0A;

  // type digits '6' + '5' of a data record, "0B8" + '5' of the end record
  localparam logic [7:0] DATA_TYPE_SUM = 8'd11;
  localparam logic [7:0] TERM_FIX_SUM  = 8'd24;

  typedef struct packed {
    logic               action;
    logic [WADDR_W-1:0] word_address;
    logic [DATA_W-1:0]  data_word;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_first;
    logic [CHAR_W-1:0] char_second;
    logic [CHAR_W-1:0] char_third;
    logic [CHAR_W-1:0] char_fourth;
    logic [2:0]        char_count;
    logic              record_end;
    logic              last_of_run;
  } out_item_t;

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_TERM = 1'b1
  } cmd_kind_t;

  // one record to print, handed from front to back
  typedef struct packed {
    cmd_kind_t          kind;
    logic               bank;
    logic [CNT_W-1:0]   count;
    logic [BADDR_W-1:0] addr;
    logic [7:0]         sum;
    logic               last;
  } cmd_t;

  // back releases a word bank once its record is printed
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_PRE,
    F_WORD,
    F_POST,
    F_TERM
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_HDR0,
    B_HDR1,
    B_HDR2,
    B_WORD,
    B_NL
  } back_state_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
    hex_char = (v < 4'd10) ? (CH_0 + {4'h0, v}) : (8'h37 + {4'h0, v});
  endfunction

  function automatic logic [7:0] nib(input logic [3:0] v);
    nib = {4'h0, v};
  endfunction

  function automatic logic [7:0] dsum4(input logic [15:0] v);
    dsum4 = nib(v[15:12]) + nib(v[11:8]) + nib(v[7:4]) + nib(v[3:0]);
  endfunction

  function automatic logic [7:0] dsum5(input logic [19:0] v);
    dsum5 = nib(v[19:16]) + nib(v[15:12]) + nib(v[11:8]) + nib(v[7:4])
          + nib(v[3:0]);
  endfunction

endpackage

// ----- rtl/core/tre_ram.sv -----
// ----------------------------------------------------------------------------
// tre_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tre_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/tre_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// tre_cmd_fifo
// Two-entry queue of record commands between front and back.
// ----------------------------------------------------------------------------
module tre_cmd_fifo
  import tre_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("cmd fifo count overflow");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
      (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("cmd fifo pointers out of step");
  a_no_lost_push: assert property (@(posedge clk) disable iff (!rst_n)
      push |-> !full)
    else $error("front pushed into full cmd fifo");

endmodule

// ----- rtl/core/tre_front.sv -----
// ----------------------------------------------------------------------------
// tre_front
// Takes items, keeps the open record, stores words, issues record commands.
// ----------------------------------------------------------------------------
module tre_front
  import tre_pkg::*;
#(
  parameter int unsigned MAX_WORDS = MAX_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  in_item_t         in_item,
  input  logic [CNT_W-1:0] wpr,
  output logic             cmd_push,
  output cmd_t             cmd_data,
  input  logic             cmd_full,
  input  rel_t             rel,
  output logic             ram_wr_en,
  output logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1):0] ram_wr_addr,
  output logic [DATA_W-1:0] ram_wr_data
);

  localparam int unsigned IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam logic [CNT_W-1:0] MAXW = CNT_W'(MAX_WORDS);

  front_state_t       state_r, state_nxt;
  in_item_t           item_r, item_nxt;
  logic               pre_r, pre_nxt;
  logic               post_r, post_nxt;
  logic [CNT_W-1:0]   held_r, held_nxt;
  logic [7:0]         sum_r, sum_nxt;
  logic [BADDR_W-1:0] rba_r, rba_nxt;
  logic [WADDR_W-1:0] prev_r, prev_nxt;
  logic               bank_r, bank_nxt;
  logic [1:0]         busy_r, busy_nxt;

  logic               accept;
  logic [CNT_W-1:0]   limit;
  logic               contig;
  logic               pre_in;
  logic [CNT_W-1:0]   held_after;
  logic               post_in;
  logic [7:0]         len;
  logic [BADDR_W-1:0] term_addr;
  logic               close_go;

  assign in_full = (state_r != F_IDLE);
  assign accept  = in_push && !in_full;

  // zero acts as one, oversize clamps to the store depth
  always_comb begin
    if (wpr == '0) begin
      limit = CNT_W'(1);
    end else if (wpr > MAXW) begin
      limit = MAXW;
    end else begin
      limit = wpr;
    end
  end

  // classify the incoming item
  always_comb begin
    contig     = ({1'b0, in_item.word_address} == ({1'b0, prev_r} + 20'd1));
    if (in_item.action) begin
      pre_in = (held_r != '0);
    end else begin
      pre_in = (held_r != '0) && (!contig || (held_r >= limit));
    end
    held_after = (pre_in ? '0 : held_r) + CNT_W'(1);
    post_in    = !in_item.action && (held_after >= limit);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (pre_in) begin
            state_nxt = F_PRE;
          end else if (in_item.action) begin
            state_nxt = F_TERM;
          end else begin
            state_nxt = F_WORD;
          end
        end
      end
      F_PRE: begin
        if (!cmd_full) begin
          state_nxt = item_r.action ? F_TERM : F_WORD;
        end
      end
      F_WORD: begin
        if (!busy_r[bank_r]) begin
          state_nxt = post_r ? F_POST : F_IDLE;
        end
      end
      F_POST: begin
        if (!cmd_full) begin
          state_nxt = F_IDLE;
        end
      end
      F_TERM: begin
        if (!cmd_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    len       = 8'd11 + {1'b0, held_r, 2'b00};
    term_addr = {item_r.word_address, 1'b0};

    item_nxt  = accept ? in_item : item_r;
    pre_nxt   = accept ? pre_in : pre_r;
    post_nxt  = accept ? post_in : post_r;
    held_nxt  = held_r;
    sum_nxt   = sum_r;
    rba_nxt   = rba_r;
    prev_nxt  = prev_r;
    bank_nxt  = bank_r;
    busy_nxt  = busy_r;
    close_go  = 1'b0;

    cmd_push       = 1'b0;
    cmd_data.kind  = CMD_DATA;
    cmd_data.bank  = bank_r;
    cmd_data.count = held_r;
    cmd_data.addr  = rba_r;
    cmd_data.sum   = nib(len[7:4]) + nib(len[3:0]) + DATA_TYPE_SUM + dsum5(rba_r) + sum_r;
    cmd_data.last  = 1'b1;

    ram_wr_en   = 1'b0;
    ram_wr_addr = {bank_r, held_r[IDX_W-1:0]};
    ram_wr_data = item_r.data_word;

    if (rel.valid) begin
      busy_nxt[rel.bank] = 1'b0;
    end

    unique case (state_r)
      F_PRE: begin
        cmd_push      = !cmd_full;
        close_go      = !cmd_full;
        cmd_data.last = !item_r.action && !post_r;
      end
      F_WORD: begin
        if (!busy_r[bank_r]) begin
          ram_wr_en = 1'b1;
          if (held_r == '0) begin
            rba_nxt = {item_r.word_address, 1'b0};
          end
          held_nxt = held_r + CNT_W'(1);
          sum_nxt  = sum_r + dsum4(item_r.data_word);
          prev_nxt = item_r.word_address;
        end
      end
      F_POST: begin
        cmd_push = !cmd_full;
        close_go = !cmd_full;
      end
      F_TERM: begin
        cmd_push       = !cmd_full;
        cmd_data.kind  = CMD_TERM;
        cmd_data.count = '0;
        cmd_data.addr  = term_addr;
        cmd_data.sum   = TERM_FIX_SUM + dsum5(term_addr);
      end
      default: begin
      end
    endcase

    // record handed over: its bank stays locked until printed
    if (close_go) begin
      busy_nxt[bank_r] = 1'b1;
      bank_nxt         = ~bank_r;
      held_nxt         = '0;
      sum_nxt          = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      held_r  <= '0;
      sum_r   <= '0;
      rba_r   <= '0;
      prev_r  <= '0;
      bank_r  <= 1'b0;
      busy_r  <= '0;
      pre_r   <= 1'b0;
      post_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      sum_r   <= sum_nxt;
      rba_r   <= rba_nxt;
      prev_r  <= prev_nxt;
      bank_r  <= bank_nxt;
      busy_r  <= busy_nxt;
      pre_r   <= pre_nxt;
      post_r  <= post_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  a_no_empty_rec: assert property (@(posedge clk) disable iff (!rst_n)
      (cmd_push && cmd_data.kind == CMD_DATA) |-> (cmd_data.count != '0))
    else $error("empty data record issued");
  a_held_max: assert property (@(posedge clk) disable iff (!rst_n)
      held_r <= MAXW)
    else $error("open record exceeds store depth");
  a_pre_used: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == F_PRE) |-> pre_r)
    else $error("pre-close state without pending close");
  a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == F_TERM) |-> (held_r == '0))
    else $error("end record issued with words still open");

endmodule

// ----- rtl/core/tre_back.sv -----
// ----------------------------------------------------------------------------
// tre_back
// Prints record commands as groups of up to four characters into the output register.
// ----------------------------------------------------------------------------
module tre_back
  import tre_pkg::*;
#(
  parameter int unsigned MAX_WORDS = MAX_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd_data,
  input  logic             cmd_empty,
  output logic             cmd_pop,
  output rel_t             rel,
  output logic             ram_rd_en,
  output logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1):0] ram_rd_addr,
  input  logic [DATA_W-1:0] ram_rd_data,
  output out_item_t        out_item,
  output logic             out_valid,
  input  logic             out_pop
);

  localparam int unsigned IDX_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  back_state_t      state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [CNT_W-1:0] widx_r, widx_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             adv;
  logic             grp_state;
  logic [7:0]       len;
  logic [CNT_W-1:0] widx_inc;
  out_item_t        grp;

  assign adv       = !out_valid_r || out_pop;
  assign grp_state = (state_r != B_IDLE);
  assign len       = 8'd11 + {1'b0, cmd_r.count, 2'b00};
  assign widx_inc  = widx_r + CNT_W'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (!cmd_empty) state_nxt = B_HDR0;
      B_HDR0: if (adv) state_nxt = B_HDR1;
      B_HDR1: if (adv) state_nxt = B_HDR2;
      B_HDR2: begin
        if (adv) begin
          state_nxt = (cmd_r.kind == CMD_DATA && cmd_r.count != '0) ? B_WORD : B_NL;
        end
      end
      B_WORD: if (adv && widx_inc == cmd_r.count) state_nxt = B_NL;
      B_NL:   if (adv) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop       = 1'b0;
    cmd_nxt       = cmd_r;
    widx_nxt      = widx_r;
    rel.valid     = 1'b0;
    rel.bank      = cmd_r.bank;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = {cmd_r.bank, widx_r[IDX_W-1:0]};

    grp.char_first  = hex_char(cmd_r.sum[7:4]);
    grp.char_second = hex_char(cmd_r.sum[3:0]);
    grp.char_third  = CH_5;
    grp.char_fourth = hex_char(cmd_r.addr[19:16]);
    grp.char_count  = 3'd4;
    grp.record_end  = 1'b0;
    grp.last_of_run = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop  = 1'b1;
          cmd_nxt  = cmd_data;
          widx_nxt = '0;
        end
      end
      B_HDR0: begin
        grp.char_first = CH_PCT;
        if (cmd_r.kind == CMD_TERM) begin
          grp.char_second = CH_0;
          grp.char_third  = CH_B;
          grp.char_fourth = CH_8;
        end else begin
          grp.char_second = hex_char(len[7:4]);
          grp.char_third  = hex_char(len[3:0]);
          grp.char_fourth = CH_6;
        end
      end
      B_HDR1: begin
      end
      B_HDR2: begin
        grp.char_first  = hex_char(cmd_r.addr[15:12]);
        grp.char_second = hex_char(cmd_r.addr[11:8]);
        grp.char_third  = hex_char(cmd_r.addr[7:4]);
        grp.char_fourth = hex_char(cmd_r.addr[3:0]);
        // fetch the first word ahead of its group
        if (adv && cmd_r.kind == CMD_DATA && cmd_r.count != '0) begin
          ram_rd_en = 1'b1;
        end
      end
      B_WORD: begin
        grp.char_first  = hex_char(ram_rd_data[15:12]);
        grp.char_second = hex_char(ram_rd_data[11:8]);
        grp.char_third  = hex_char(ram_rd_data[7:4]);
        grp.char_fourth = hex_char(ram_rd_data[3:0]);
        if (adv) begin
          widx_nxt    = widx_inc;
          ram_rd_addr = {cmd_r.bank, widx_inc[IDX_W-1:0]};
          ram_rd_en   = (widx_inc != cmd_r.count);
        end
      end
      B_NL: begin
        grp.char_first  = CH_NL;
        grp.char_second = '0;
        grp.char_third  = '0;
        grp.char_fourth = '0;
        grp.char_count  = 3'd1;
        grp.record_end  = 1'b1;
        grp.last_of_run = cmd_r.last;
        rel.valid       = adv && (cmd_r.kind == CMD_DATA);
      end
      default: begin
      end
    endcase

    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_pop;
    if (grp_state && adv) begin
      out_nxt       = grp;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    widx_r <= widx_nxt;
    out_r  <= out_nxt;
  end

  assign out_item  = out_r;
  assign out_valid = out_valid_r;

  a_widx_range: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == B_WORD) |-> (widx_r < cmd_r.count))
    else $error("word index past record length");
  a_word_data_only: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == B_WORD) |-> (cmd_r.kind == CMD_DATA))
    else $error("end record reached word state");
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && !out_pop) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled group changed");

endmodule

// ----- rtl/core/tekhex_record_encoder.sv -----
// ----------------------------------------------------------------------------
// tekhex_record_encoder
// Extended hex data-record encoder: words in, ASCII record text out.
// ----------------------------------------------------------------------------
// Push 16-bit words with their 19-bit word addresses; the block gathers them
// into one open record and prints it as text in groups of up to four
// characters on the out_ side: '%', length, '6', checksum, '5', five-digit
// byte address, four hex digits per word, newline. A record closes at the
// configured word count (cfg_data, 0 reads as 1, above MAX_WORDS clamps),
// at an address gap, or on an end-of-file item, which also prints the end
// record "%0B8", checksum, '5' and the byte transfer address. A word that
// closes nothing is accepted and then stored; one that closes a record,
// and the end item, also issue commands, as long as the command queue has
// room. Printing runs at one group per cycle while out_pop keeps up, a
// record of n words being 4 + n groups plus an idle state to fetch its
// command; that printer is the sustained limit once records close often.
// Words are held in two banks of a small RAM so the next record fills
// while the last one prints; a word's store stalls only if both banks are
// still waiting to print. last_of_run marks the final group caused by one
// pushed item. Write the word count only while no output is outstanding.
// ----------------------------------------------------------------------------
module tekhex_record_encoder
  import tre_pkg::*;
#(
  parameter int unsigned MAX_WORDS = MAX_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  in_item_t         in_item,
  output logic             out_empty,
  input  logic             out_pop,
  output out_item_t        out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data
);

  localparam int unsigned IDX_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned RAM_DP = 2 << IDX_W;   // two banks

  logic [CNT_W-1:0] wpr_r, wpr_nxt;

  cmd_t             f_cmd, b_cmd;
  logic             f_cmd_push, q_full, q_empty, b_cmd_pop;
  rel_t             rel;
  logic             ram_wr_en, ram_rd_en;
  logic [IDX_W:0]   ram_wr_addr, ram_rd_addr;
  logic [DATA_W-1:0] ram_wr_data, ram_rd_data;
  logic             out_valid;

  // register write port never stalls
  assign cfg_ready = 1'b1;
  assign wpr_nxt   = (cfg_valid && cfg_ready) ? cfg_data : wpr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpr_r <= WPR_RESET;
    end else begin
      wpr_r <= wpr_nxt;
    end
  end

  tre_front #(.MAX_WORDS(MAX_WORDS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_item     (in_item),
    .wpr         (wpr_r),
    .cmd_push    (f_cmd_push),
    .cmd_data    (f_cmd),
    .cmd_full    (q_full),
    .rel         (rel),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data)
  );

  tre_cmd_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_cmd_push),
    .push_data (f_cmd),
    .full      (q_full),
    .pop       (b_cmd_pop),
    .pop_data  (b_cmd),
    .empty     (q_empty)
  );

  tre_ram #(.WIDTH(DATA_W), .DEPTH(RAM_DP)) u_words (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  tre_back #(.MAX_WORDS(MAX_WORDS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_data    (b_cmd),
    .cmd_empty   (q_empty),
    .cmd_pop     (b_cmd_pop),
    .rel         (rel),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .out_item    (out_item),
    .out_valid   (out_valid),
    .out_pop     (out_pop)
  );

  assign out_empty = !out_valid;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
      !out_empty |-> (out_item.char_count >= 3'd1 && out_item.char_count <= 3'd4))
    else $error("group char count out of range");
  a_end_is_nl: assert property (@(posedge clk) disable iff (!rst_n)
      (!out_empty && out_item.record_end) |->
      (out_item.char_count == 3'd1 && out_item.char_first == CH_NL))
    else $error("record end group is not a lone newline");
  a_last_ends_rec: assert property (@(posedge clk) disable iff (!rst_n)
      (!out_empty && out_item.last_of_run) |-> out_item.record_end)
    else $error("last of run inside a record");

endmodule
